### sv/cls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cls_pkg;

	// field widths
	localparam int unsigned SizeW   = 32;
	localparam int unsigned LenW    = 17;
	localparam int unsigned TokenW  = 32;
	localparam int unsigned ResultW = 16;
	localparam int unsigned OpW     = 2;
	localparam int unsigned StatusW = 4;

	// register reset values and chunk clamp
	localparam logic [SizeW-1:0] TotalSizeReset  = 32'd1;
	localparam logic [LenW-1:0]  ChunkLimitReset = 17'd4096;
	localparam logic [LenW-1:0]  MaxChunk        = 17'd65536;

	// stream packing
	localparam int unsigned InDataW  = 88;
	localparam int unsigned OutDataW = 56;

	// configuration register indexes
	localparam int unsigned CfgIdxW = 1;
	localparam logic [CfgIdxW-1:0] RegTotalSize  = 1'b0;
	localparam logic [CfgIdxW-1:0] RegChunkLimit = 1'b1;

	typedef enum logic [OpW-1:0] {
		OP_NEXT    = 2'd0,
		OP_ACK     = 2'd1,
		OP_ABORT   = 2'd2,
		OP_RESTART = 2'd3
	} op_t;

	typedef enum logic [StatusW-1:0] {
		ST_OK        = 4'd0,
		ST_INVALID   = 4'd1,
		ST_ALREADY   = 4'd2,
		ST_BUSY      = 4'd3,
		ST_CANCELLED = 4'd4,
		ST_PROTOCOL  = 4'd5,
		ST_STALE     = 4'd6,
		ST_REMOTE    = 4'd7,
		ST_PIPE      = 4'd8
	} status_t;

	typedef struct packed {
		logic [SizeW-1:0]  committed_offset;
		logic [SizeW-1:0]  pending_offset;
		logic [LenW-1:0]   pending_length;
		logic [TokenW-1:0] awaited_token;
		logic              awaiting_ack;
		logic              load_done;
		logic              cleanup_flag;
	} seq_state_t;

	typedef struct packed {
		op_t                op;
		logic [TokenW-1:0]  token;
		logic [ResultW-1:0] partner_code;
		logic               peer_reset;
		logic [SizeW-1:0]   reported_left;
	} request_t;

	typedef struct packed {
		status_t          status;
		logic [SizeW-1:0] chunk_offset;
		logic [LenW-1:0]  chunk_length;
		logic             done_res;
		logic             needs_cleanup;
	} result_t;

endpackage

`default_nettype wire

### sv/cls_step.sv
`timescale 1ns / 1ps
`default_nettype none

module cls_step import cls_pkg::*; (
	input  wire seq_state_t       state,
	input  wire request_t         req,
	input  wire logic [SizeW-1:0] image_bytes,
	input  wire logic [LenW-1:0]  chunk_limit,
	output seq_state_t            state_next,
	output result_t               res
);

	logic [LenW-1:0]  limit_eff;
	logic [SizeW-1:0] left;
	logic [SizeW-1:0] expect_rem;
	logic [LenW-1:0]  grant_len;
	logic [SizeW-1:0] commit_end;

	// clamp the chunk limit into 1..65536
	always_comb begin
		if (chunk_limit == '0) begin
			limit_eff = LenW'(1);
		end else if (chunk_limit > MaxChunk) begin
			limit_eff = MaxChunk;
		end else begin
			limit_eff = chunk_limit;
		end
	end

	// chunk size and expected remainder
	always_comb begin
		left       = image_bytes - state.committed_offset;
		grant_len  = (left > {{(SizeW-LenW){1'b0}}, limit_eff}) ?
		             limit_eff : left[LenW-1:0];
		commit_end = state.pending_offset + {{(SizeW-LenW){1'b0}}, state.pending_length};
		expect_rem = image_bytes - commit_end;
	end

	// request decode and state update
	always_comb begin
		state_next       = state;
		res.status       = ST_OK;
		res.chunk_offset = '0;
		res.chunk_length = '0;
		case (req.op)
			OP_NEXT: begin
				if (req.token == '0) begin
					res.status = ST_INVALID;
				end else if (state.load_done) begin
					res.status = ST_ALREADY;
				end else if (state.awaiting_ack) begin
					res.status = ST_BUSY;
				end else if (state.cleanup_flag) begin
					res.status = ST_CANCELLED;
				end else if (state.committed_offset >= image_bytes) begin
					res.status = ST_PROTOCOL;
				end else begin
					state_next.pending_offset = state.committed_offset;
					state_next.pending_length = grant_len;
					state_next.awaited_token  = req.token;
					state_next.awaiting_ack   = 1'b1;
					res.chunk_offset          = state.committed_offset;
					res.chunk_length          = grant_len;
				end
			end
			OP_ACK: begin
				if (!state.awaiting_ack) begin
					res.status = ST_INVALID;
				end else if (req.token != state.awaited_token) begin
					res.status = ST_STALE;
				end else begin
					state_next.awaiting_ack = 1'b0;
					if (req.partner_code != '0) begin
						state_next.cleanup_flag = 1'b1;
						res.status              = ST_REMOTE;
					end else if (req.peer_reset) begin
						state_next.cleanup_flag = 1'b1;
						res.status              = ST_PIPE;
					end else if (req.reported_left != expect_rem) begin
						state_next.cleanup_flag = 1'b1;
						res.status              = ST_PROTOCOL;
					end else begin
						state_next.committed_offset = commit_end;
						state_next.pending_length   = '0;
						if (req.reported_left == '0) begin
							state_next.load_done = 1'b1;
						end
					end
				end
			end
			OP_ABORT: begin
				if (!state.load_done) begin
					if (state.awaiting_ack || state.committed_offset != '0 ||
					    state.pending_length != '0) begin
						state_next.cleanup_flag = 1'b1;
					end
					state_next.awaiting_ack = 1'b0;
				end
			end
			OP_RESTART: begin
				state_next = '0;
			end
			default: begin
				state_next = state;
			end
		endcase
		res.done_res      = state_next.load_done;
		res.needs_cleanup = state_next.cleanup_flag;
	end

endmodule

`default_nettype wire

### sv/chunked_load_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  handshake                fields
// s_*       in         s_tvalid / s_tready      request: op, token, remote result, reset, size
// m_*       out        m_tvalid / m_tready      result: status, chunk, done, cleanup
// cfg_*     in         cfg_valid / cfg_ready    register index and write data
//
// one request per cycle sustained while the output is not stalled; a request is held
// in the input register and is evaluated against the sequencer state on its way to
// the output register, which holds the result until it is taken.
// reset clears the sequencer state and loads image size 1, chunk_limit 4096.
// a stalled output holds the result and stops the input register.
// configuration writes are always taken.

module chunked_load_sequencer import cls_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// token[31:0], partner_code[47:32], peer_reset[48], reported_left[80:49]
	input  wire logic [InDataW-1:0]  s_tdata,
	// op[1:0]
	input  wire logic [OpW-1:0]      s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// chunk_offset[31:0], chunk_length[48:32], done_res[49], needs_cleanup[50]
	output logic [OutDataW-1:0]      m_tdata,
	// status[3:0]
	output logic [StatusW-1:0]       m_tuser,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CfgIdxW-1:0]  cfg_index,
	input  wire logic [SizeW-1:0]    cfg_data
);

	logic             valid_s1;
	request_t         req_s1;
	logic             out_valid_q;
	result_t          out_q;
	seq_state_t       state_q;
	seq_state_t       state_next;
	result_t          res;
	logic [SizeW-1:0] image_bytes_q;
	logic [LenW-1:0]  chunk_limit_q;
	logic             advance;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_bytes_q <= TotalSizeReset;
			chunk_limit_q <= ChunkLimitReset;
		end else if (cfg_valid) begin
			case (cfg_index)
				RegTotalSize:  image_bytes_q <= cfg_data;
				RegChunkLimit: chunk_limit_q <= cfg_data[LenW-1:0];
				default:       image_bytes_q <= image_bytes_q;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.op            <= op_t'(s_tuser);
			req_s1.token         <= s_tdata[31:0];
			req_s1.partner_code  <= s_tdata[47:32];
			req_s1.peer_reset    <= s_tdata[48];
			req_s1.reported_left <= s_tdata[80:49];
		end
	end

	cls_step u_step (
		.state       (state_q),
		.req         (req_s1),
		.image_bytes (image_bytes_q),
		.chunk_limit (chunk_limit_q),
		.state_next  (state_next),
		.res         (res)
	);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {5'b0, out_q.needs_cleanup, out_q.done_res,
	                   out_q.chunk_length, out_q.chunk_offset};

endmodule

`default_nettype wire
